// File: rtl/dtoi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtoi_pkg
// Shared types and constants for the decimal text to integer unit.
// ----------------------------------------------------------------------------
package dtoi_pkg;

    // width of the converted integer
    localparam int WIDTH   = 32;
    localparam int VALUE_W = 32;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // magnitude limit for a negative result
    localparam logic [WIDTH-1:0] LIMIT_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic               is_negative;
        logic               overflowed;
        logic [WIDTH-1:0]   accumulator;
    } parse_state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               range_error;
    } parse_result_t;

    localparam parse_state_t STATE_IDLE = '{
        phase:       PH_SKIP,
        is_negative: 1'b0,
        overflowed:  1'b0,
        accumulator: '0
    };

endpackage

// File: rtl/dtoi_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtoi_parse
// Next-state and result logic for one text byte: whitespace skip, sign,
// multiply-by-ten accumulate with overflow detect, final value at the NUL.
// ----------------------------------------------------------------------------
module dtoi_parse (
    input  logic [7:0]             char_code,
    input  dtoi_pkg::parse_state_t cur,
    output dtoi_pkg::parse_state_t nxt,
    output dtoi_pkg::parse_result_t result
);

    logic                         is_space;
    logic                         is_digit;
    logic [3:0]                   digit;
    logic [dtoi_pkg::WIDTH+3:0]   prod;
    logic                         digit_ovf;
    logic                         err;
    logic [dtoi_pkg::WIDTH-1:0]   res_full;
    dtoi_pkg::parse_state_t       with_digit;

    assign is_space = (char_code == dtoi_pkg::CHAR_SPACE)
                   || (char_code inside {[dtoi_pkg::CHAR_TAB:dtoi_pkg::CHAR_CR]});
    assign is_digit = char_code inside {[dtoi_pkg::CHAR_ZERO:dtoi_pkg::CHAR_NINE]};
    assign digit    = 4'(char_code - dtoi_pkg::CHAR_ZERO);

    // acc * 10 + d as (acc << 3) + (acc << 1) + d
    assign prod = {1'b0, cur.accumulator, 3'b000}
                + {3'b000, cur.accumulator, 1'b0}
                + (dtoi_pkg::WIDTH+4)'(digit);
    assign digit_ovf = |prod[dtoi_pkg::WIDTH+3:dtoi_pkg::WIDTH];

    always_comb
    begin
        with_digit = cur;
        if (digit_ovf)
        begin
            with_digit.overflowed = 1'b1;
            with_digit.phase      = dtoi_pkg::PH_STOP;
        end
        else
        begin
            with_digit.phase       = dtoi_pkg::PH_DIGITS;
            with_digit.accumulator = prod[dtoi_pkg::WIDTH-1:0];
        end
    end

    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            dtoi_pkg::PH_SKIP:
            begin
                if (is_space)
                begin
                    nxt = cur;
                end
                else if (char_code == dtoi_pkg::CHAR_MINUS)
                begin
                    nxt.is_negative = 1'b1;
                    nxt.phase       = dtoi_pkg::PH_DIGITS;
                end
                else if (char_code == dtoi_pkg::CHAR_PLUS)
                begin
                    nxt.phase = dtoi_pkg::PH_DIGITS;
                end
                else if (is_digit)
                begin
                    nxt = with_digit;
                end
                else
                begin
                    nxt.phase = dtoi_pkg::PH_STOP;
                end
            end
            dtoi_pkg::PH_DIGITS:
            begin
                if (is_digit)
                    nxt = with_digit;
                else
                    nxt.phase = dtoi_pkg::PH_STOP;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    assign err = cur.overflowed
              || (cur.is_negative && (cur.accumulator > dtoi_pkg::LIMIT_NEG));

    always_comb
    begin
        if (err)
            res_full = '1;
        else if (cur.is_negative)
            res_full = '0 - cur.accumulator;
        else
            res_full = cur.accumulator;
    end

    assign result.value       = dtoi_pkg::VALUE_W'(res_full);
    assign result.range_error = err;

endmodule

// File: rtl/decimal_text_to_integer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer_unit
// Converts a NUL-terminated decimal text, one byte per beat, to an integer.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle without gaps while the output side keeps up.
// A byte is registered on input and then processed by a single multiply-by-ten
// accumulate step that updates the parse state; that state loop sets the
// rate. The NUL byte produces one result beat, visible once the NUL has passed
// from the input register through the processing stage, held in an output register so
// the next text can stream in while the result waits. A stalled output only
// stalls input when a further NUL reaches the processing stage.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic        range_error
);

    logic                    in_valid_reg;
    logic [7:0]              char_reg;
    dtoi_pkg::parse_state_t  state_reg;
    dtoi_pkg::parse_state_t  state_next;
    dtoi_pkg::parse_state_t  parse_nxt;
    dtoi_pkg::parse_result_t parse_res;
    logic                    out_valid_reg;
    dtoi_pkg::parse_result_t result_reg;
    logic                    is_nul;
    logic                    advance;

    assign is_nul  = (char_reg == dtoi_pkg::CHAR_NUL);
    // a terminator needs a free output slot, other bytes always go
    assign advance = in_valid_reg && (!is_nul || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dtoi_parse u_parse (
        .char_code (char_reg),
        .cur       (state_reg),
        .nxt       (parse_nxt),
        .result    (parse_res)
    );

    always_comb
    begin
        state_next = state_reg;
        if (advance)
            state_next = is_nul ? dtoi_pkg::STATE_IDLE : parse_nxt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= dtoi_pkg::STATE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            state_reg <= state_next;
            if (advance && is_nul)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            char_reg <= char_code;
        if (advance && is_nul)
            result_reg <= parse_res;
    end

    assign out_valid   = out_valid_reg;
    assign value       = result_reg.value;
    assign range_error = result_reg.range_error;

    // an error result always carries the all-ones pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> value == '1)
        else $error("range error without all-ones value");

    // the terminator returns the parser to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_nul |=> state_reg.phase == dtoi_pkg::PH_SKIP
            && state_reg.accumulator == '0 && !state_reg.overflowed
            && !state_reg.is_negative)
        else $error("parser not idle after terminator");

    // a pending result is never overwritten by the next terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_valid_reg && is_nul |-> !advance)
        else $error("result overwritten while stalled");

    // a waiting input byte holds until processed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(char_reg))
        else $error("input stage lost a byte");

endmodule

// File: bench/decimal_text_to_integer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_integer_unit_tb
// Streams zero-terminated decimal texts into the unit and checks every
// converted value against a cycle-free model of the parser. Covers
// whitespace, signs, stray bytes and range limits. Both sides of the
// handshake are throttled, and one long output stall backs the unit up.
// ----------------------------------------------------------------------------
module decimal_text_to_integer_unit_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int STALL_CYCLES   = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 1260;

    // parser model plus the queue of conversions still owed by the unit
    class text_value_scoreboard;
        dtoi_pkg::phase_t           ph;
        logic                       neg;
        logic                       ovf;
        logic [dtoi_pkg::WIDTH-1:0] mag;
        dtoi_pkg::parse_result_t    owed_values[$];
        int                         errors;

        function new();
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            ph  = dtoi_pkg::PH_SKIP;
            neg = 1'b0;
            ovf = 1'b0;
            mag = '0;
        endfunction

        function void add_digit(logic [7:0] c);
            logic [dtoi_pkg::WIDTH-1:0] maxu;
            logic [dtoi_pkg::WIDTH-1:0] cutoff;
            logic [dtoi_pkg::WIDTH-1:0] cutlim;
            logic [dtoi_pkg::WIDTH-1:0] d;
            maxu   = '1;
            cutoff = maxu / 10;
            cutlim = maxu % 10;
            d      = dtoi_pkg::WIDTH'(c - dtoi_pkg::CHAR_ZERO);
            if (mag > cutoff || (mag == cutoff && d > cutlim))
            begin
                ovf = 1'b1;
                ph  = dtoi_pkg::PH_STOP;
            end
            else
            begin
                mag = mag * 10 + d;
            end
        endfunction

        function void take_char(logic [7:0] c);
            logic                       err;
            logic [dtoi_pkg::WIDTH-1:0] full;
            dtoi_pkg::parse_result_t    r;
            if (c == dtoi_pkg::CHAR_NUL)
            begin
                err = ovf || (neg && mag > dtoi_pkg::LIMIT_NEG);
                if (err)
                    full = '1;
                else if (neg)
                    full = -mag;
                else
                    full = mag;
                r.value       = dtoi_pkg::VALUE_W'(full);
                r.range_error = err;
                owed_values.push_back(r);
                clear_parse();
                return;
            end
            case (ph)
                dtoi_pkg::PH_SKIP:
                begin
                    if (c == dtoi_pkg::CHAR_SPACE
                        || c inside {[dtoi_pkg::CHAR_TAB:dtoi_pkg::CHAR_CR]})
                    begin
                        // whitespace keeps skipping
                    end
                    else if (c == dtoi_pkg::CHAR_MINUS)
                    begin
                        neg = 1'b1;
                        ph  = dtoi_pkg::PH_DIGITS;
                    end
                    else if (c == dtoi_pkg::CHAR_PLUS)
                    begin
                        ph = dtoi_pkg::PH_DIGITS;
                    end
                    else if (c inside {[dtoi_pkg::CHAR_ZERO:dtoi_pkg::CHAR_NINE]})
                    begin
                        ph = dtoi_pkg::PH_DIGITS;
                        add_digit(c);
                    end
                    else
                    begin
                        ph = dtoi_pkg::PH_STOP;
                    end
                end
                dtoi_pkg::PH_DIGITS:
                begin
                    if (c inside {[dtoi_pkg::CHAR_ZERO:dtoi_pkg::CHAR_NINE]})
                        add_digit(c);
                    else
                        ph = dtoi_pkg::PH_STOP;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_value(logic [dtoi_pkg::VALUE_W-1:0] v, logic e);
            dtoi_pkg::parse_result_t exp_r;
            if (owed_values.size() == 0)
            begin
                $error("result beat with nothing expected: value %h range_error %b", v, e);
                errors++;
                return;
            end
            exp_r = owed_values.pop_front();
            if (v !== exp_r.value)
            begin
                $error("value: expected %h, actual %h", exp_r.value, v);
                errors++;
            end
            if (e !== exp_r.range_error)
            begin
                $error("range_error: expected %b, actual %b", exp_r.range_error, e);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [7:0]                   char_code;
    logic                         out_valid;
    logic                         out_ready;
    logic [dtoi_pkg::VALUE_W-1:0] value;
    logic                         range_error;

    text_value_scoreboard sb;
    logic [7:0]           text_buf[$];
    int                   tx_idle_pct;
    int                   rx_idle_pct;
    int                   bytes_sent;
    int                   quiet_cycles;
    bit                   stall_request;

    decimal_text_to_integer_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .range_error (range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_char(char_code);
            if (out_valid && out_ready)
                sb.check_value(value, range_error);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("decimal_text_to_integer_unit_tb: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_char(text_buf[i]);
        send_char(dtoi_pkg::CHAR_NUL);
        text_buf.delete();
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic send_string(input string s);
        push_string(s);
        send_text();
    endtask

    function automatic logic [7:0] any_space();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? dtoi_pkg::CHAR_SPACE : dtoi_pkg::CHAR_TAB + 8'(k);
    endfunction

    task automatic build_random_text();
        int          kind;
        logic [63:0] n;
        int          len;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            repeat ($urandom_range(2)) text_buf.push_back(any_space());
            case ($urandom_range(2))
                0: text_buf.push_back(dtoi_pkg::CHAR_MINUS);
                1: text_buf.push_back(dtoi_pkg::CHAR_PLUS);
                default: ;
            endcase
            repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
                text_buf.push_back(dtoi_pkg::CHAR_ZERO);
            case ($urandom_range(9))
                0, 1, 2, 3, 4: n = {$urandom, $urandom} >> $urandom_range(63);
                5, 6: n = 64'hFFFF_FFFF + $urandom_range(4) - 2;
                7, 8: n = 64'h8000_0000 + $urandom_range(4) - 2;
                default: n = $urandom_range(999);
            endcase
            push_string($sformatf("%0d", n));
            if ($urandom_range(1))
                repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
        end
        else if (kind < 85)
        begin
            // broken sequences built from the characters the parser cares about
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                case ($urandom_range(3))
                    0: text_buf.push_back(any_space());
                    1: text_buf.push_back($urandom_range(1) ? dtoi_pkg::CHAR_PLUS
                                                             : dtoi_pkg::CHAR_MINUS);
                    default: text_buf.push_back(dtoi_pkg::CHAR_ZERO + 8'($urandom_range(9)));
                endcase
            end
        end
        else
        begin
            repeat ($urandom_range(8)) text_buf.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic send_random(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            build_random_text();
            send_text();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_code     = '0;
        stall_request = 1'b0;
        bytes_sent    = 0;
        quiet_cycles  = 0;
        tx_idle_pct   = 32;
        rx_idle_pct   = 82;
        sb            = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed texts
        send_string("");
        for (int c = dtoi_pkg::CHAR_TAB; c <= dtoi_pkg::CHAR_CR; c++)
            text_buf.push_back(8'(c));
        text_buf.push_back(dtoi_pkg::CHAR_SPACE);
        send_text();
        send_string("-");
        send_string("+");
        send_string("x12");
        send_string("- 5");
        send_string("4294967295");
        send_string("4294967296");
        send_string("-2147483648");
        send_string("-2147483649");
        send_string(" +0012ab34");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h80);
        send_string("7");
        send_string("99999999999999999999");

        send_random(RANDOM_BYTES / 3);
        tx_idle_pct = 82;
        rx_idle_pct = 32;
        send_random(RANDOM_BYTES / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // output held off while short texts keep coming, so the unit backs up
        stall_request = 1'b1;
        send_random(RANDOM_BYTES / 3);
        in_valid <= 1'b0;

        while (sb.owed_values.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("decimal_text_to_integer_unit_tb: PASS");
        else
            $display("decimal_text_to_integer_unit_tb: FAIL");
        $finish;
    end

endmodule
